### design/uetu_pkg.sv
// types, codes and helper functions for the unicode escape to utf-8 decoder
// no dependencies; used by uetu_decode, uetu_outbuf and unicode_escape_to_utf8
package uetu_pkg;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] LETTER_U  = 8'h75;

	typedef enum logic [2:0] {
		PH_TEXT = 3'd0,
		PH_BSL  = 3'd1,
		PH_ESC1 = 3'd2,
		PH_ESC2 = 3'd3,
		PH_ESC3 = 3'd4,
		PH_ESC4 = 3'd5
	} phase_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] nib;
	} hex_t;

	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       last;
	} res_t;

	function automatic hex_t hex_decode(logic [7:0] b);
		hex_t h;
		h = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.hit = 1'b1;
			h.nib = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.hit = 1'b1;
			h.nib = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.hit = 1'b1;
			h.nib = 4'(b - 8'h37);
		end
		return h;
	endfunction

	function automatic res_t utf8_encode(logic [15:0] cp);
		res_t r;
		r = '0;
		if (cp <= 16'h007F) begin
			r.n  = 2'd1;
			r.b0 = cp[7:0];
		end else if (cp <= 16'h07FF) begin
			r.n  = 2'd2;
			r.b0 = {3'b110, cp[10:6]};
			r.b1 = {2'b10, cp[5:0]};
		end else begin
			r.n  = 2'd3;
			r.b0 = {4'b1110, cp[15:12]};
			r.b1 = {2'b10, cp[11:6]};
			r.b2 = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

### design/uetu_text_if.sv
// escaped text channel and decoded utf-8 channel, valid/ready handshake
// no dependencies
interface uetu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface uetu_utf8_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

### design/uetu_decode.sv
// escape state machine: phase, code accumulator and result bytes for one item
// depends on uetu_pkg
module uetu_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [7:0]         data,
	input  logic               last,
	output uetu_pkg::res_t     res
);

	uetu_pkg::phase_t phase_q, phase_d;
	logic [15:0]      acc_q, acc_d, acc_ext;
	logic             open_q, open_d;
	uetu_pkg::hex_t   hex;
	logic             is_bsl, is_u;

	assign hex     = uetu_pkg::hex_decode(data);
	assign is_bsl  = (data == uetu_pkg::BACKSLASH);
	assign is_u    = (data == uetu_pkg::LETTER_U);
	assign acc_ext = (open_q && hex.hit) ? {acc_q[11:0], hex.nib} : acc_q;

	// next state
	always_comb begin
		phase_d = uetu_pkg::PH_TEXT;
		acc_d   = acc_q;
		open_d  = open_q;
		unique case (phase_q)
			uetu_pkg::PH_BSL: begin
				if (is_u) begin
					phase_d = uetu_pkg::PH_ESC1;
					acc_d   = '0;
					open_d  = 1'b1;
				end else if (is_bsl && !last) begin
					phase_d = uetu_pkg::PH_BSL;
				end
			end
			uetu_pkg::PH_ESC1, uetu_pkg::PH_ESC2, uetu_pkg::PH_ESC3,
			uetu_pkg::PH_ESC4: begin
				acc_d  = acc_ext;
				open_d = open_q && hex.hit;
				if (phase_q == uetu_pkg::PH_ESC4 || last) begin
					acc_d  = '0;
					open_d = 1'b0;
				end else begin
					phase_d = uetu_pkg::phase_t'(phase_q + 3'd1);
				end
			end
			default: begin
				if (is_bsl && !last) begin
					phase_d = uetu_pkg::PH_BSL;
				end
			end
		endcase
		if (last) begin
			phase_d = uetu_pkg::PH_TEXT;
			acc_d   = '0;
			open_d  = 1'b0;
		end
	end

	// result bytes
	always_comb begin
		res = '0;
		unique case (phase_q)
			uetu_pkg::PH_BSL: begin
				if (is_u) begin
					if (last) begin
						res = uetu_pkg::utf8_encode('0);
					end
				end else begin
					res.n  = 2'd1;
					res.b0 = uetu_pkg::BACKSLASH;
					if (!(is_bsl && !last)) begin
						res.n  = 2'd2;
						res.b1 = data;
					end
				end
			end
			uetu_pkg::PH_ESC1, uetu_pkg::PH_ESC2, uetu_pkg::PH_ESC3,
			uetu_pkg::PH_ESC4: begin
				if (phase_q == uetu_pkg::PH_ESC4 || last) begin
					res = uetu_pkg::utf8_encode(acc_ext);
				end
			end
			default: begin
				if (!(is_bsl && !last)) begin
					res.n  = 2'd1;
					res.b0 = data;
				end
			end
		endcase
		res.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uetu_pkg::PH_TEXT;
			acc_q   <= '0;
			open_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			open_q  <= open_d;
		end
	end

endmodule

### design/uetu_outbuf.sv
// result register: holds up to three bytes of one item and shifts them out
// depends on uetu_pkg and uetu_utf8_if
module uetu_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  uetu_pkg::res_t ld,
	output logic           free,
	uetu_utf8_if.source    utf8
);

	logic [1:0] cnt_q;
	logic [7:0] b_q [3];
	logic       last_q;
	logic       pop;

	assign pop           = utf8.valid && utf8.ready;
	assign free          = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign utf8.valid    = (cnt_q != 2'd0);
	assign utf8.out_byte = b_q[0];
	assign utf8.out_last = last_q && (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ld.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			b_q[0] <= ld.b0;
			b_q[1] <= ld.b1;
			b_q[2] <= ld.b2;
			last_q <= ld.last;
		end else if (pop) begin
			b_q[0] <= b_q[1];
			b_q[1] <= b_q[2];
		end
	end

endmodule

### design/unicode_escape_to_utf8.sv
// path: an accepted item is held in the input stage, then loaded into the result register
// throughput: one item per cycle while each gives at most one byte and the output is
// ready; an item that expands to two or three utf-8 bytes holds the input until its last
// byte is taken (one byte per cycle at the output while it is ready)
// reset: asynchronous, clears the input stage, escape phase, accumulator and result count
module unicode_escape_to_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	uetu_text_if.sink  text,
	uetu_utf8_if.source utf8
);

	logic           valid_s1;
	logic [7:0]     data_s1;
	logic           last_s1;
	logic           free;
	logic           load;
	uetu_pkg::res_t res;

	assign load       = valid_s1 && free;
	assign text.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			data_s1 <= text.in_byte;
			last_s1 <= text.in_last;
		end
	end

	uetu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (load),
		.data    (data_s1),
		.last    (last_s1),
		.res     (res)
	);

	uetu_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.ld     (res),
		.free   (free),
		.utf8   (utf8)
	);

endmodule

### design/uetu_checker.sv
// port-level checks for the decoder, bound to unicode_escape_to_utf8
// depends on the top level's channel ports
module uetu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_ready,
	input logic       utf8_valid,
	input logic       utf8_ready,
	input logic [7:0] utf8_byte,
	input logic       utf8_last
);

	// input only stalls when a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> utf8_valid)
		else $error("input stalled with no result pending");

	// nothing pending straight out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !utf8_valid)
		else $error("result valid straight after reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && !utf8_ready |=> utf8_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && !utf8_ready |=> $stable(utf8_byte) && $stable(utf8_last))
		else $error("result changed while stalled");

endmodule

bind unicode_escape_to_utf8 uetu_checker u_uetu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_ready (text.ready),
	.utf8_valid (utf8.valid),
	.utf8_ready (utf8.ready),
	.utf8_byte  (utf8.out_byte),
	.utf8_last  (utf8.out_last)
);
